// ===== rtl/chte_pkg.sv =====
// ----------------------------------------------------------------------------
// chte_pkg
// Shared constants, opcodes and controller/datapath interface structs for the
// chained hash table engine.
// ----------------------------------------------------------------------------
package chte_pkg;

    localparam int POOL_NODES  = 256;
    localparam int NODE_W      = 8;
    localparam int LINK_W      = 9;
    localparam int BKT_W       = 8;
    localparam int CNT_W       = 9;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int SCAN_CHUNK  = 16;

    localparam logic [LINK_W-1:0] NODE_NIL        = 9'd256;
    localparam logic [CNT_W-1:0]  POOL_COUNT      = 9'd256;
    localparam logic [CNT_W-1:0]  FALLBACK_BUCKETS = 9'd7;
    localparam logic [CNT_W-1:0]  MAX_BUCKETS     = 9'd256;
    localparam logic [CNT_W-1:0]  RESET_BUCKETS   = 9'd251;

    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_REMOVE = 3'd1;
    localparam logic [2:0] OP_GET    = 3'd2;
    localparam logic [2:0] OP_PEEK   = 3'd3;
    localparam logic [2:0] OP_TAKE   = 3'd4;
    localparam logic [2:0] OP_EBEGIN = 3'd5;
    localparam logic [2:0] OP_ENEXT  = 3'd6;
    localparam logic [2:0] OP_EEND   = 3'd7;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_MISS = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;

    typedef struct packed {
        logic load;
        logic mod_start;
        logic site_from_mod;
        logic site_from_scan;
        logic rd_head;
        logic add_commit;
        logic ptr_from_head;
        logic ptr_from_cursor;
        logic rd_node;
        logic hit_commit;
        logic advance;
        logic miss;
        logic full;
        logic enum_step;
        logic scan_start_zero;
        logic scan_start_next;
        logic scan_step;
        logic cursor_from_head;
        logic cursor_clear;
        logic res_load;
    } cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       pool_empty;
        logic       mod_done;
        logic       head_nonempty;
        logic       key_hit;
        logic       link_nil;
        logic       cursor_nil;
        logic       scan_hit;
        logic       scan_none;
    } sts_t;

endpackage

// ===== rtl/chte_mod.sv =====
// ----------------------------------------------------------------------------
// chte_mod
// Iterative remainder unit: 32-bit dividend modulo a 9-bit divisor, four
// restoring steps per cycle.
// ----------------------------------------------------------------------------
module chte_mod (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [chte_pkg::KEY_W-1:0]  dividend,
    input  logic [chte_pkg::CNT_W-1:0]  divisor,
    output logic                        done,
    output logic [chte_pkg::BKT_W-1:0]  remainder
);

    logic                       busy_reg;
    logic                       done_reg;
    logic [2:0]                 cnt_reg;
    logic [chte_pkg::KEY_W-1:0] shift_reg;
    logic [chte_pkg::BKT_W-1:0] rem_reg;
    logic [chte_pkg::BKT_W-1:0] rem_next;

    always_comb begin
        logic [chte_pkg::BKT_W:0] t;
        rem_next = rem_reg;
        for (int i = 0; i < 4; i++) begin
            t = {rem_next, shift_reg[chte_pkg::KEY_W-1-i]};
            if (t >= divisor) begin
                t = t - divisor;
            end
            rem_next = t[chte_pkg::BKT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 3'd0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd7) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            shift_reg <= dividend;
            rem_reg   <= '0;
        end else if (busy_reg) begin
            shift_reg <= {shift_reg[chte_pkg::KEY_W-5:0], 4'b0000};
            rem_reg   <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/chte_ctrl.sv =====
// ----------------------------------------------------------------------------
// chte_ctrl
// Operation sequencer: dispatches each item and steps the datapath through
// key reduction, bucket scan, chain walk and commit.
// ----------------------------------------------------------------------------
module chte_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             out_free,
    input  chte_pkg::sts_t   sts,
    output chte_pkg::cmd_t   cmd
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_DISP = 4'd1;
    localparam logic [3:0] ST_MOD  = 4'd2;
    localparam logic [3:0] ST_RDH  = 4'd3;
    localparam logic [3:0] ST_HEAD = 4'd4;
    localparam logic [3:0] ST_RDN  = 4'd5;
    localparam logic [3:0] ST_NODE = 4'd6;
    localparam logic [3:0] ST_SCAN = 4'd7;
    localparam logic [3:0] ST_FIN  = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       forced_hit;

    assign in_ready   = (state_reg == ST_IDLE);
    assign forced_hit = (sts.op == chte_pkg::OP_PEEK) || (sts.op == chte_pkg::OP_TAKE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISP;
                end
            end
            ST_DISP: begin
                unique case (sts.op)
                    chte_pkg::OP_ADD: begin
                        if (sts.pool_empty) begin
                            cmd.full   = 1'b1;
                            state_next = ST_FIN;
                        end else begin
                            cmd.mod_start = 1'b1;
                            state_next    = ST_MOD;
                        end
                    end
                    chte_pkg::OP_REMOVE, chte_pkg::OP_GET, chte_pkg::OP_PEEK: begin
                        cmd.mod_start = 1'b1;
                        state_next    = ST_MOD;
                    end
                    chte_pkg::OP_TAKE, chte_pkg::OP_EBEGIN: begin
                        cmd.scan_start_zero = 1'b1;
                        state_next          = ST_SCAN;
                    end
                    chte_pkg::OP_ENEXT: begin
                        if (sts.cursor_nil) begin
                            cmd.miss   = 1'b1;
                            state_next = ST_FIN;
                        end else begin
                            cmd.ptr_from_cursor = 1'b1;
                            state_next          = ST_RDN;
                        end
                    end
                    default: begin
                        cmd.cursor_clear = 1'b1;
                        state_next       = ST_FIN;
                    end
                endcase
            end
            ST_MOD: begin
                if (sts.mod_done) begin
                    cmd.site_from_mod = 1'b1;
                    state_next        = ST_RDH;
                end
            end
            ST_RDH: begin
                cmd.rd_head = 1'b1;
                state_next  = ST_HEAD;
            end
            ST_HEAD: begin
                unique case (sts.op)
                    chte_pkg::OP_ADD: begin
                        cmd.add_commit = 1'b1;
                        state_next     = ST_FIN;
                    end
                    chte_pkg::OP_EBEGIN, chte_pkg::OP_ENEXT: begin
                        cmd.cursor_from_head = 1'b1;
                        state_next           = ST_FIN;
                    end
                    default: begin
                        if (sts.head_nonempty) begin
                            cmd.ptr_from_head = 1'b1;
                            state_next        = ST_RDN;
                        end else begin
                            cmd.miss   = 1'b1;
                            state_next = ST_FIN;
                        end
                    end
                endcase
            end
            ST_RDN: begin
                cmd.rd_node = 1'b1;
                state_next  = ST_NODE;
            end
            ST_NODE: begin
                if (sts.op == chte_pkg::OP_ENEXT) begin
                    cmd.enum_step = 1'b1;
                    if (sts.link_nil) begin
                        cmd.scan_start_next = 1'b1;
                        state_next          = ST_SCAN;
                    end else begin
                        state_next = ST_FIN;
                    end
                end else if (forced_hit || sts.key_hit) begin
                    cmd.hit_commit = 1'b1;
                    state_next     = ST_FIN;
                end else if (sts.link_nil) begin
                    cmd.miss   = 1'b1;
                    state_next = ST_FIN;
                end else begin
                    cmd.advance = 1'b1;
                    state_next  = ST_RDN;
                end
            end
            ST_SCAN: begin
                if (sts.scan_none) begin
                    if (sts.op == chte_pkg::OP_TAKE) begin
                        cmd.miss = 1'b1;
                    end else if (sts.op == chte_pkg::OP_EBEGIN) begin
                        cmd.cursor_clear = 1'b1;
                    end
                    state_next = ST_FIN;
                end else if (sts.scan_hit) begin
                    cmd.site_from_scan = 1'b1;
                    state_next         = ST_RDH;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/chte_dpath.sv =====
// ----------------------------------------------------------------------------
// chte_dpath
// Bucket heads, node pool, free list, enumeration cursor, bucket scan and
// result registers of the chained hash table engine.
// ----------------------------------------------------------------------------
module chte_dpath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  chte_pkg::cmd_t              cmd,
    output chte_pkg::sts_t              sts,
    input  logic [2:0]                  in_opcode,
    input  logic [chte_pkg::KEY_W-1:0]  in_key,
    input  logic [chte_pkg::VAL_W-1:0]  in_value,
    input  logic [chte_pkg::BKT_W-1:0]  in_bucket_select,
    input  logic                        cfg_wr_en,
    input  logic [chte_pkg::CNT_W-1:0]  cfg_wr_data,
    output logic [1:0]                  res_status,
    output logic [chte_pkg::VAL_W-1:0]  res_found_value,
    output logic [chte_pkg::BKT_W-1:0]  res_bucket_index,
    output logic [chte_pkg::CNT_W-1:0]  res_entry_count
);

    // memories
    logic [chte_pkg::NODE_W-1:0] head_mem [chte_pkg::POOL_NODES];
    logic [chte_pkg::KEY_W-1:0]  key_mem  [chte_pkg::POOL_NODES];
    logic [chte_pkg::VAL_W-1:0]  val_mem  [chte_pkg::POOL_NODES];
    logic [chte_pkg::LINK_W-1:0] link_mem [chte_pkg::POOL_NODES];
    logic [chte_pkg::NODE_W-1:0] free_mem [chte_pkg::POOL_NODES];

    logic [chte_pkg::NODE_W-1:0] head_rd_reg;
    logic [chte_pkg::NODE_W-1:0] free_rd_reg;
    logic [chte_pkg::KEY_W-1:0]  key_rd_reg;
    logic [chte_pkg::VAL_W-1:0]  val_rd_reg;
    logic [chte_pkg::LINK_W-1:0] link_rd_reg;

    // control state
    logic [chte_pkg::POOL_NODES-1:0] nonempty_reg;
    logic [chte_pkg::NODE_W-1:0]     free_head_reg;
    logic [chte_pkg::CNT_W-1:0]      free_count_reg;
    logic                            wrapped_reg;
    logic [chte_pkg::LINK_W-1:0]     cursor_node_reg;
    logic [chte_pkg::BKT_W-1:0]      cursor_bucket_reg;
    logic [chte_pkg::CNT_W-1:0]      bucket_count_reg;

    // item payload and work registers
    logic [2:0]                  op_reg;
    logic [chte_pkg::KEY_W-1:0]  key_reg;
    logic [chte_pkg::VAL_W-1:0]  val_reg;
    logic [chte_pkg::BKT_W-1:0]  sel_reg;
    logic [chte_pkg::BKT_W-1:0]  site_reg;
    logic [chte_pkg::NODE_W-1:0] cur_reg;
    logic [chte_pkg::LINK_W-1:0] prev_reg;
    logic [chte_pkg::CNT_W-1:0]  scan_ptr_reg;
    logic [1:0]                  status_reg;
    logic [chte_pkg::VAL_W-1:0]  found_reg;
    logic [chte_pkg::BKT_W-1:0]  bidx_reg;

    logic [chte_pkg::CNT_W-1:0]  nb;
    logic                        mod_done;
    logic [chte_pkg::BKT_W-1:0]  mod_rem;
    logic [chte_pkg::KEY_W-1:0]  mod_dividend;

    logic [chte_pkg::NODE_W-1:0] new_node;
    logic                        unlink;
    logic                        head_we;
    logic [chte_pkg::NODE_W-1:0] head_wdata;
    logic                        link_we;
    logic [chte_pkg::NODE_W-1:0] link_waddr;
    logic [chte_pkg::LINK_W-1:0] link_wdata;
    logic                        free_we;
    logic [chte_pkg::NODE_W-1:0] free_waddr;

    logic [3:0]                  scan_chunk;
    logic [chte_pkg::SCAN_CHUNK-1:0] scan_bits;
    logic                        scan_hit;
    logic [3:0]                  scan_pos;
    logic [chte_pkg::CNT_W-1:0]  scan_ptr_step;

    always_comb begin
        if (bucket_count_reg < 9'd2) begin
            nb = chte_pkg::FALLBACK_BUCKETS;
        end else if (bucket_count_reg > chte_pkg::MAX_BUCKETS) begin
            nb = chte_pkg::MAX_BUCKETS;
        end else begin
            nb = bucket_count_reg;
        end
    end

    assign mod_dividend = (op_reg == chte_pkg::OP_PEEK)
                        ? {{(chte_pkg::KEY_W-chte_pkg::BKT_W){1'b0}}, sel_reg} : key_reg;

    chte_mod u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.mod_start),
        .dividend  (mod_dividend),
        .divisor   (nb),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    // first pass through the free list reads the reset order directly
    assign new_node   = wrapped_reg ? free_rd_reg : free_head_reg;
    assign unlink     = (op_reg == chte_pkg::OP_REMOVE) || (op_reg == chte_pkg::OP_TAKE);
    assign head_we    = cmd.add_commit || (cmd.hit_commit && unlink && prev_reg[chte_pkg::NODE_W]);
    assign head_wdata = cmd.add_commit ? new_node : link_rd_reg[chte_pkg::NODE_W-1:0];
    assign link_we    = cmd.add_commit || (cmd.hit_commit && unlink && !prev_reg[chte_pkg::NODE_W]);
    assign link_waddr = cmd.add_commit ? new_node : prev_reg[chte_pkg::NODE_W-1:0];
    assign link_wdata = cmd.add_commit
                      ? (nonempty_reg[site_reg] ? {1'b0, head_rd_reg} : chte_pkg::NODE_NIL)
                      : link_rd_reg;
    assign free_we    = cmd.hit_commit && unlink;
    assign free_waddr = free_head_reg + free_count_reg[chte_pkg::NODE_W-1:0];

    // bucket scan, sixteen buckets per cycle
    assign scan_chunk = scan_ptr_reg[7:4];
    assign scan_bits  = nonempty_reg[scan_chunk*chte_pkg::SCAN_CHUNK +: chte_pkg::SCAN_CHUNK];

    always_comb begin
        logic [chte_pkg::CNT_W-1:0] idx;
        scan_hit = 1'b0;
        scan_pos = 4'd0;
        for (int i = chte_pkg::SCAN_CHUNK - 1; i >= 0; i--) begin
            idx = {1'b0, scan_chunk, 4'(i)};
            if (scan_bits[i] && (4'(i) >= scan_ptr_reg[3:0]) && (idx < nb)) begin
                scan_hit = 1'b1;
                scan_pos = 4'(i);
            end
        end
    end

    assign scan_ptr_step = {({1'b0, scan_chunk} + 5'd1), 4'b0000};

    always_ff @(posedge aclk) begin
        if (cmd.rd_head) begin
            head_rd_reg <= head_mem[site_reg];
            free_rd_reg <= free_mem[free_head_reg];
        end
        if (head_we) begin
            head_mem[site_reg] <= head_wdata;
        end
        if (free_we) begin
            free_mem[free_waddr] <= cur_reg;
        end
        if (cmd.rd_node) begin
            key_rd_reg  <= key_mem[cur_reg];
            val_rd_reg  <= val_mem[cur_reg];
            link_rd_reg <= link_mem[cur_reg];
        end
        if (cmd.add_commit) begin
            key_mem[new_node] <= key_reg;
            val_mem[new_node] <= val_reg;
        end
        if (link_we) begin
            link_mem[link_waddr] <= link_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nonempty_reg      <= '0;
            free_head_reg     <= '0;
            free_count_reg    <= chte_pkg::POOL_COUNT;
            wrapped_reg       <= 1'b0;
            cursor_node_reg   <= chte_pkg::NODE_NIL;
            cursor_bucket_reg <= '0;
            bucket_count_reg  <= chte_pkg::RESET_BUCKETS;
        end else begin
            if (cfg_wr_en) begin
                bucket_count_reg <= cfg_wr_data;
            end
            if (cmd.add_commit) begin
                nonempty_reg[site_reg] <= 1'b1;
                free_head_reg          <= free_head_reg + 8'd1;
                free_count_reg         <= free_count_reg - 9'd1;
                if (free_head_reg == 8'hFF) begin
                    wrapped_reg <= 1'b1;
                end
            end
            if (head_we && !cmd.add_commit) begin
                nonempty_reg[site_reg] <= !link_rd_reg[chte_pkg::NODE_W];
            end
            if (free_we) begin
                free_count_reg <= free_count_reg + 9'd1;
            end
            if (cmd.cursor_clear || free_we) begin
                cursor_node_reg   <= chte_pkg::NODE_NIL;
                cursor_bucket_reg <= '0;
            end
            if (cmd.enum_step) begin
                cursor_node_reg <= link_rd_reg;
            end
            if (cmd.cursor_from_head) begin
                cursor_node_reg   <= {1'b0, head_rd_reg};
                cursor_bucket_reg <= site_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg     <= in_opcode;
            key_reg    <= in_key;
            val_reg    <= in_value;
            sel_reg    <= in_bucket_select;
            status_reg <= chte_pkg::STAT_OK;
            found_reg  <= '0;
            bidx_reg   <= '0;
        end
        if (cmd.site_from_mod) begin
            site_reg <= mod_rem;
        end
        if (cmd.site_from_scan) begin
            site_reg <= {scan_chunk, scan_pos};
        end
        if (cmd.ptr_from_head) begin
            cur_reg  <= head_rd_reg;
            prev_reg <= chte_pkg::NODE_NIL;
        end
        if (cmd.ptr_from_cursor) begin
            cur_reg <= cursor_node_reg[chte_pkg::NODE_W-1:0];
        end
        if (cmd.advance) begin
            prev_reg <= {1'b0, cur_reg};
            cur_reg  <= link_rd_reg[chte_pkg::NODE_W-1:0];
        end
        if (cmd.scan_start_zero) begin
            scan_ptr_reg <= '0;
        end
        if (cmd.scan_start_next) begin
            scan_ptr_reg <= {1'b0, cursor_bucket_reg} + 9'd1;
        end
        if (cmd.scan_step) begin
            scan_ptr_reg <= scan_ptr_step;
        end
        if (cmd.miss) begin
            status_reg <= chte_pkg::STAT_MISS;
        end
        if (cmd.full) begin
            status_reg <= chte_pkg::STAT_FULL;
        end
        if (cmd.hit_commit || cmd.enum_step) begin
            found_reg <= val_rd_reg;
        end
        if (cmd.hit_commit && (op_reg == chte_pkg::OP_TAKE)) begin
            bidx_reg <= site_reg;
        end
    end

    always_comb begin
        sts               = '0;
        sts.op            = op_reg;
        sts.pool_empty    = (free_count_reg == '0);
        sts.mod_done      = mod_done;
        sts.head_nonempty = nonempty_reg[site_reg];
        sts.key_hit       = (key_rd_reg == key_reg);
        sts.link_nil      = link_rd_reg[chte_pkg::NODE_W];
        sts.cursor_nil    = cursor_node_reg[chte_pkg::NODE_W];
        sts.scan_hit      = scan_hit;
        sts.scan_none     = (scan_ptr_reg >= nb);
    end

    assign res_status       = status_reg;
    assign res_found_value  = found_reg;
    assign res_bucket_index = bidx_reg;
    assign res_entry_count  = chte_pkg::POOL_COUNT - free_count_reg;

endmodule

// ===== rtl/chained_hash_table_engine_core.sv =====
// ----------------------------------------------------------------------------
// chained_hash_table_engine_core
// Throughput: one item at a time; the next item is accepted in the cycle after
// the result is loaded. The key remainder unit, the bucket scan (16 buckets per
// cycle) and the chain walk set how long each item takes, and a finished result
// waits while the output register still holds an item not yet taken. Reset: all
// buckets empty, free list in node order, cursor none, bucket count 251; items
// are taken right after.
// ----------------------------------------------------------------------------
module chained_hash_table_engine_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // key[31:0], value[63:32], bucket_select[71:64]
    input  logic [2:0]  s_tuser,   // opcode[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // found_value[31:0], bucket_index[39:32],
                                   // entry_count[48:40], zero[55:49]
    output logic [1:0]  m_tuser,   // status[1:0]
    input  logic        cfg_wr_en,
    input  logic [8:0]  cfg_wr_data
);

    chte_pkg::cmd_t cmd;
    chte_pkg::sts_t sts;

    logic        out_free;
    logic        m_tvalid_reg;
    logic [55:0] m_tdata_reg;
    logic [1:0]  m_tuser_reg;

    logic [1:0]  res_status;
    logic [31:0] res_found_value;
    logic [7:0]  res_bucket_index;
    logic [8:0]  res_entry_count;

    assign out_free = !m_tvalid_reg || m_tready;

    chte_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .out_free (out_free),
        .sts      (sts),
        .cmd      (cmd)
    );

    chte_dpath u_dpath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .in_opcode        (s_tuser),
        .in_key           (s_tdata[31:0]),
        .in_value         (s_tdata[63:32]),
        .in_bucket_select (s_tdata[71:64]),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .res_status       (res_status),
        .res_found_value  (res_found_value),
        .res_bucket_index (res_bucket_index),
        .res_entry_count  (res_entry_count)
    );

    // output register holds one finished item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.res_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            m_tdata_reg <= {7'd0, res_entry_count, res_bucket_index, res_found_value};
            m_tuser_reg <= res_status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.res_load |-> (!m_tvalid_reg || m_tready))
        else $error("result loaded over an item not yet taken");

    a_add_has_node: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.add_commit |-> !sts.pool_empty)
        else $error("add committed with an empty pool");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.hit_commit && (sts.op == chte_pkg::OP_REMOVE || sts.op == chte_pkg::OP_TAKE)
        |=> res_entry_count == $past(res_entry_count) - 9'd1)
        else $error("entry count not decremented on removal");

endmodule

// ===== verif/chained_hash_table_engine_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// chained_hash_table_engine_core_tb
// Drives hash table operations over several bucket counts with random gaps and
// result stalls, predicts every response with a behavioral table and checks
// each response field by field.
// ----------------------------------------------------------------------------
module chained_hash_table_engine_core_tb;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] key;
        logic [31:0] value;
        logic [7:0]  sel;
    } op_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] found;
        logic [7:0]  bidx;
        logic [8:0]  count;
    } resp_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [55:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_wr_en = 0;
    logic [8:0]  cfg_wr_data = '0;

    chained_hash_table_engine_core dut (.*);

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    // behavioral table
    logic [8:0]  heads [256];
    logic [31:0] nkey [256];
    logic [31:0] nval [256];
    logic [8:0]  nlink [256];
    logic [7:0]  free_ring [256];
    int unsigned free_head, free_cnt, stored, cur_bucket, nbuckets_reg;
    logic [8:0]  cur_node;

    op_item_t pending_ops [$];
    resp_t    expected_resps [$];
    int       fail_count = 0;
    bit       stim_done = 0;

    function automatic int unsigned active_buckets();
        if (nbuckets_reg < 2) return int'(chte_pkg::FALLBACK_BUCKETS);
        if (nbuckets_reg > 256) return 256;
        return nbuckets_reg;
    endfunction

    function automatic int unsigned first_bucket(int unsigned start, int unsigned nb);
        for (int unsigned b = start; b < nb; b++)
            if (heads[b] != chte_pkg::NODE_NIL) return b;
        return nb;
    endfunction

    function automatic void table_reset();
        for (int i = 0; i < 256; i++) begin
            heads[i] = chte_pkg::NODE_NIL;
            free_ring[i] = 8'(i);
        end
        free_head = 0;
        free_cnt = 256;
        stored = 0;
        cur_node = chte_pkg::NODE_NIL;
        cur_bucket = 0;
        nbuckets_reg = int'(chte_pkg::RESET_BUCKETS);
    endfunction

    function automatic void free_node(logic [8:0] n);
        free_ring[(free_head + free_cnt) % 256] = n[7:0];
        free_cnt++;
    endfunction

    function automatic resp_t table_apply(op_item_t it);
        resp_t r;
        int unsigned nb, site, b;
        logic [8:0] n, prev;
        nb = active_buckets();
        site = it.key % nb;
        r = '0;
        case (it.op)
            chte_pkg::OP_ADD: begin
                if (free_cnt == 0) r.status = chte_pkg::STAT_FULL;
                else begin
                    n = {1'b0, free_ring[free_head]};
                    free_head = (free_head + 1) % 256;
                    free_cnt--;
                    nkey[n[7:0]] = it.key;
                    nval[n[7:0]] = it.value;
                    nlink[n[7:0]] = heads[site];
                    heads[site] = n;
                    stored++;
                end
            end
            chte_pkg::OP_REMOVE: begin
                prev = chte_pkg::NODE_NIL;
                n = heads[site];
                while (n != chte_pkg::NODE_NIL && nkey[n[7:0]] != it.key) begin
                    prev = n;
                    n = nlink[n[7:0]];
                end
                if (n == chte_pkg::NODE_NIL) r.status = chte_pkg::STAT_MISS;
                else begin
                    if (prev == chte_pkg::NODE_NIL) heads[site] = nlink[n[7:0]];
                    else nlink[prev[7:0]] = nlink[n[7:0]];
                    r.found = nval[n[7:0]];
                    free_node(n);
                    stored--;
                    cur_node = chte_pkg::NODE_NIL;
                    cur_bucket = 0;
                end
            end
            chte_pkg::OP_GET: begin
                n = heads[site];
                while (n != chte_pkg::NODE_NIL && nkey[n[7:0]] != it.key) n = nlink[n[7:0]];
                if (n == chte_pkg::NODE_NIL) r.status = chte_pkg::STAT_MISS;
                else r.found = nval[n[7:0]];
            end
            chte_pkg::OP_PEEK: begin
                n = heads[it.sel % nb];
                if (n == chte_pkg::NODE_NIL) r.status = chte_pkg::STAT_MISS;
                else r.found = nval[n[7:0]];
            end
            chte_pkg::OP_TAKE: begin
                b = first_bucket(0, nb);
                if (b >= nb) r.status = chte_pkg::STAT_MISS;
                else begin
                    n = heads[b];
                    heads[b] = nlink[n[7:0]];
                    r.found = nval[n[7:0]];
                    r.bidx = 8'(b);
                    free_node(n);
                    stored--;
                    cur_node = chte_pkg::NODE_NIL;
                    cur_bucket = 0;
                end
            end
            chte_pkg::OP_EBEGIN: begin
                b = first_bucket(0, nb);
                if (b >= nb) begin
                    cur_node = chte_pkg::NODE_NIL;
                    cur_bucket = 0;
                end else begin
                    cur_node = heads[b];
                    cur_bucket = b;
                end
            end
            chte_pkg::OP_ENEXT: begin
                if (cur_node == chte_pkg::NODE_NIL) r.status = chte_pkg::STAT_MISS;
                else begin
                    r.found = nval[cur_node[7:0]];
                    cur_node = nlink[cur_node[7:0]];
                    if (cur_node == chte_pkg::NODE_NIL) begin
                        b = first_bucket(cur_bucket + 1, nb);
                        if (b < nb) begin
                            cur_node = heads[b];
                            cur_bucket = b;
                        end
                    end
                end
            end
            default: begin
                cur_node = chte_pkg::NODE_NIL;
                cur_bucket = 0;
            end
        endcase
        r.count = 9'(stored);
        return r;
    endfunction

    // sender: bursts with random gaps
    int burst_left = 0, gap_left = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_resps.push_back(
                    table_apply(op_item_t'({s_tuser, s_tdata[31:0], s_tdata[63:32],
                                            s_tdata[71:64]})));
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 0;
                end else if (pending_ops.size() > 0) begin
                    op_item_t it;
                    it = pending_ops.pop_front();
                    s_tvalid <= 1;
                    s_tuser <= it.op;
                    s_tdata <= {it.sel, it.value, it.key};
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_tvalid <= 0;
                end
            end
        end
    end

    // receiver: stall pattern with quiet stretches
    int stall_phase = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            stall_phase <= (stall_phase + 1) % 64;
            m_tready <= (stall_phase < 20) ? 1'b1 : ($urandom_range(0, 3) != 0);
            if (m_tvalid && m_tready) begin
                resp_t got, exp_r;
                got = {m_tuser, m_tdata[31:0], m_tdata[39:32], m_tdata[48:40]};
                if (expected_resps.size() == 0) begin
                    $error("unexpected response status=%0d", got.status);
                    fail_count++;
                end else begin
                    exp_r = expected_resps.pop_front();
                    if (got.status != exp_r.status) begin
                        $error("status exp %0d got %0d", exp_r.status, got.status);
                        fail_count++;
                    end
                    if (got.found != exp_r.found) begin
                        $error("found_value exp %h got %h", exp_r.found, got.found);
                        fail_count++;
                    end
                    if (got.bidx != exp_r.bidx) begin
                        $error("bucket_index exp %0d got %0d", exp_r.bidx, got.bidx);
                        fail_count++;
                    end
                    if (got.count != exp_r.count) begin
                        $error("entry_count exp %0d got %0d", exp_r.count, got.count);
                        fail_count++;
                    end
                    if (m_tdata[55:49] != 7'd0) begin
                        $error("pad exp 0 got %h", m_tdata[55:49]);
                        fail_count++;
                    end
                end
            end
        end
    end

    function automatic op_item_t mk(logic [2:0] op, logic [31:0] k, logic [31:0] v,
                                    logic [7:0] s);
        op_item_t it;
        it.op = op;
        it.key = k;
        it.value = v;
        it.sel = s;
        return it;
    endfunction

    logic [31:0] key_pool [$];

    function automatic op_item_t random_op(int unsigned nb);
        logic [31:0] k;
        int unsigned r;
        r = $urandom_range(0, 99);
        if (key_pool.size() > 0 && $urandom_range(0, 3) != 0)
            k = key_pool[$urandom_range(0, key_pool.size() - 1)];
        else if ($urandom_range(0, 1)) k = $urandom_range(0, 3 * nb);
        else k = $urandom;
        if (r < 35) begin
            key_pool.push_back(k);
            if (key_pool.size() > 40) void'(key_pool.pop_front());
            return mk(chte_pkg::OP_ADD, k, $urandom, 8'($urandom));
        end
        if (r < 50) return mk(chte_pkg::OP_REMOVE, k, $urandom, 8'($urandom));
        if (r < 62) return mk(chte_pkg::OP_GET, k, $urandom, 8'($urandom));
        if (r < 70) return mk(chte_pkg::OP_PEEK, $urandom, $urandom, 8'($urandom));
        if (r < 78) return mk(chte_pkg::OP_TAKE, $urandom, $urandom, 8'($urandom));
        if (r < 82) return mk(chte_pkg::OP_EBEGIN, $urandom, $urandom, 8'($urandom));
        if (r < 97) return mk(chte_pkg::OP_ENEXT, $urandom, $urandom, 8'($urandom));
        return mk(chte_pkg::OP_EEND, $urandom, $urandom, 8'($urandom));
    endfunction

    task automatic drain();
        while (pending_ops.size() > 0 || expected_resps.size() > 0 || s_tvalid)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_buckets(logic [8:0] v);
        cfg_wr_data <= v;
        cfg_wr_en <= 1;
        @(posedge aclk);
        cfg_wr_en <= 0;
        nbuckets_reg = v;
        @(posedge aclk);
    endtask

    initial begin
        logic [8:0] settings [6];
        int unsigned nb;
        settings = '{9'd2, 9'd0, 9'd256, 9'd511, 9'd13, 9'd97};
        table_reset();
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: empty table, extremes, collisions in one chain
        pending_ops.push_back(mk(chte_pkg::OP_TAKE, 32'd0, 32'd0, 8'd0));
        pending_ops.push_back(mk(chte_pkg::OP_EBEGIN, 32'd0, 32'd0, 8'd0));
        pending_ops.push_back(mk(chte_pkg::OP_ENEXT, 32'd0, 32'd0, 8'd0));
        pending_ops.push_back(mk(chte_pkg::OP_PEEK, 32'd0, 32'd0, 8'hff));
        pending_ops.push_back(mk(chte_pkg::OP_GET, 32'hffffffff, 32'd0, 8'd0));
        pending_ops.push_back(mk(chte_pkg::OP_ADD, 32'hffffffff, 32'hffffffff, 8'hff));
        pending_ops.push_back(mk(chte_pkg::OP_ADD, 32'd0, 32'h0, 8'd0));
        pending_ops.push_back(mk(chte_pkg::OP_ADD, 32'd251, 32'h1111, 8'd0));
        pending_ops.push_back(mk(chte_pkg::OP_ADD, 32'd251, 32'h2222, 8'd0));
        pending_ops.push_back(mk(chte_pkg::OP_GET, 32'd251, 32'd0, 8'd0));
        pending_ops.push_back(mk(chte_pkg::OP_PEEK, 32'd0, 32'd0, 8'd0));
        pending_ops.push_back(mk(chte_pkg::OP_EBEGIN, 32'd0, 32'd0, 8'd0));
        pending_ops.push_back(mk(chte_pkg::OP_ENEXT, 32'd0, 32'd0, 8'd0));
        pending_ops.push_back(mk(chte_pkg::OP_ENEXT, 32'd0, 32'd0, 8'd0));
        pending_ops.push_back(mk(chte_pkg::OP_REMOVE, 32'd0, 32'd0, 8'd0));
        pending_ops.push_back(mk(chte_pkg::OP_ENEXT, 32'd0, 32'd0, 8'd0));
        pending_ops.push_back(mk(chte_pkg::OP_REMOVE, 32'd12345, 32'd0, 8'd0));
        pending_ops.push_back(mk(chte_pkg::OP_TAKE, 32'd0, 32'd0, 8'd0));
        pending_ops.push_back(mk(chte_pkg::OP_EBEGIN, 32'd0, 32'd0, 8'd0));
        pending_ops.push_back(mk(chte_pkg::OP_EEND, 32'd0, 32'd0, 8'd0));
        pending_ops.push_back(mk(chte_pkg::OP_ENEXT, 32'd0, 32'd0, 8'd0));
        drain();

        // fill the pool to overflow, then empty it by take
        for (int i = 0; i < 258; i++)
            pending_ops.push_back(mk(chte_pkg::OP_ADD, $urandom, $urandom, 8'd0));
        for (int i = 0; i < 100; i++) pending_ops.push_back(random_op(251));
        for (int i = 0; i < 260; i++)
            pending_ops.push_back(mk(chte_pkg::OP_TAKE, 32'd0, 32'd0, 8'd0));
        drain();

        // random phases across bucket counts; entries carry over between them
        foreach (settings[p]) begin
            write_buckets(settings[p]);
            nb = active_buckets();
            for (int i = 0; i < 200; i++) pending_ops.push_back(random_op(nb));
            drain();
        end
        write_buckets(chte_pkg::RESET_BUCKETS);
        for (int i = 0; i < 150; i++) pending_ops.push_back(random_op(251));
        drain();

        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("FAIL");
        $finish;
    end

endmodule
